// ----- hw/rtl/uart_rx_tx_ring_buffers_macros.svh -----
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers_macros
// Assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef UART_RX_TX_RING_BUFFERS_MACROS_SVH
`define UART_RX_TX_RING_BUFFERS_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define URTRB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define URTRB_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hw/rtl/urtrb_pkg.sv -----
// ----------------------------------------------------------------------------
// urtrb_pkg
// Types and codes shared by the UART receive/transmit ring buffer block.
// ----------------------------------------------------------------------------
`default_nettype none

package urtrb_pkg;

    localparam int BYTE_W = 8;
    localparam int OP_W   = 3;
    localparam int ST_W   = 3;
    localparam int FILL_W = 6;

    // Operation codes
    localparam logic [OP_W-1:0] OP_RX_ARRIVE = 3'd0;
    localparam logic [OP_W-1:0] OP_RX_TAKE   = 3'd1;
    localparam logic [OP_W-1:0] OP_TX_PUT    = 3'd2;
    localparam logic [OP_W-1:0] OP_TX_READY  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR_RX  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR_TX  = 3'd5;
    localparam logic [OP_W-1:0] OP_START     = 3'd6;
    localparam logic [OP_W-1:0] OP_STOP      = 3'd7;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK             = 3'd0;
    localparam logic [ST_W-1:0] ST_RX_EMPTY       = 3'd1;
    localparam logic [ST_W-1:0] ST_TX_OVERFLOW    = 3'd2;
    localparam logic [ST_W-1:0] ST_RX_OVERWROTE   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_RUNNING    = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] data_byte;
        logic              port_accepts;
    } t_in_req;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [BYTE_W-1:0] rx_byte;
        logic              tx_offer_valid;
        logic [BYTE_W-1:0] tx_offer_byte;
        logic [FILL_W-1:0] rx_fill;
        logic [FILL_W-1:0] tx_fill;
    } t_out_res;

    // Per-request result of the control step, completed once ring data is read
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic              rx_take;
        logic              tx_offer_valid;
        logic              tx_from_ring;
        logic [BYTE_W-1:0] tx_in_byte;
        logic [FILL_W-1:0] rx_fill;
        logic [FILL_W-1:0] tx_fill;
    } t_ctl_info;

endpackage

`default_nettype wire

// ----- hw/rtl/urtrb_mem.sv -----
// ----------------------------------------------------------------------------
// urtrb_mem
// Byte ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module urtrb_mem #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [AW-1:0]                 i_waddr,
    input  wire logic [urtrb_pkg::BYTE_W-1:0]  i_wdata,
    input  wire logic                          i_re,
    input  wire logic [AW-1:0]                 i_raddr,
    output logic      [urtrb_pkg::BYTE_W-1:0]  o_rdata
);

    logic [urtrb_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [urtrb_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/urtrb_ctrl.sv -----
// ----------------------------------------------------------------------------
// urtrb_ctrl
// Ring pointers, port and run state; decodes one accepted request per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module urtrb_ctrl #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64,
    localparam int RX_AW = $clog2(RX_DEPTH),
    localparam int TX_AW = $clog2(TX_DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire urtrb_pkg::t_in_req   i_req,
    output urtrb_pkg::t_ctl_info      o_info,
    output logic                      o_rx_we,
    output logic                      o_rx_re,
    output logic [RX_AW-1:0]          o_rx_waddr,
    output logic [RX_AW-1:0]          o_rx_raddr,
    output logic                      o_tx_we,
    output logic                      o_tx_re,
    output logic [TX_AW-1:0]          o_tx_waddr,
    output logic [TX_AW-1:0]          o_tx_raddr
);

    localparam int RX_CW = (RX_AW + 1 > urtrb_pkg::FILL_W) ? RX_AW + 1 : urtrb_pkg::FILL_W;
    localparam int TX_CW = (TX_AW + 1 > urtrb_pkg::FILL_W) ? TX_AW + 1 : urtrb_pkg::FILL_W;
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

    logic [RX_AW-1:0] r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [TX_AW-1:0] r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic             r_port_free, n_port_free;
    logic             r_running, n_running;
    logic [RX_AW-1:0] rx_tail_inc;
    logic [TX_AW-1:0] tx_tail_inc;
    logic             tx_empty;

    function automatic logic [RX_AW-1:0] rx_bump(input logic [RX_AW-1:0] p);
        return (p == RX_LAST) ? '0 : p + RX_AW'(1);
    endfunction

    function automatic logic [TX_AW-1:0] tx_bump(input logic [TX_AW-1:0] p);
        return (p == TX_LAST) ? '0 : p + TX_AW'(1);
    endfunction

    function automatic logic [urtrb_pkg::FILL_W-1:0] rx_count(
        input logic [RX_AW-1:0] h,
        input logic [RX_AW-1:0] t
    );
        logic [RX_CW-1:0] d;
        d = RX_CW'(t) - RX_CW'(h);
        if (t < h) d = d + RX_CW'(RX_DEPTH);
        return d[urtrb_pkg::FILL_W-1:0];
    endfunction

    function automatic logic [urtrb_pkg::FILL_W-1:0] tx_count(
        input logic [TX_AW-1:0] h,
        input logic [TX_AW-1:0] t
    );
        logic [TX_CW-1:0] d;
        d = TX_CW'(t) - TX_CW'(h);
        if (t < h) d = d + TX_CW'(TX_DEPTH);
        return d[urtrb_pkg::FILL_W-1:0];
    endfunction

    assign rx_tail_inc = rx_bump(r_rx_tail);
    assign tx_tail_inc = tx_bump(r_tx_tail);
    assign tx_empty    = (r_tx_head == r_tx_tail);

    assign o_rx_waddr = r_rx_tail;
    assign o_rx_raddr = r_rx_head;
    assign o_tx_waddr = r_tx_tail;
    assign o_tx_raddr = r_tx_head;

    always_comb begin
        n_rx_head   = r_rx_head;
        n_rx_tail   = r_rx_tail;
        n_tx_head   = r_tx_head;
        n_tx_tail   = r_tx_tail;
        n_port_free = r_port_free;
        n_running   = r_running;
        o_rx_we     = 1'b0;
        o_rx_re     = 1'b0;
        o_tx_we     = 1'b0;
        o_tx_re     = 1'b0;
        o_info.status         = urtrb_pkg::ST_OK;
        o_info.rx_take        = 1'b0;
        o_info.tx_offer_valid = 1'b0;
        o_info.tx_from_ring   = 1'b0;
        o_info.tx_in_byte     = i_req.data_byte;

        if (i_accept) begin
            case (i_req.operation)
                urtrb_pkg::OP_RX_ARRIVE: begin
                    // full ring drops its oldest byte
                    o_rx_we   = 1'b1;
                    n_rx_tail = rx_tail_inc;
                    if (rx_tail_inc == r_rx_head) begin
                        n_rx_head     = rx_bump(r_rx_head);
                        o_info.status = urtrb_pkg::ST_RX_OVERWROTE;
                    end
                end
                urtrb_pkg::OP_RX_TAKE: begin
                    if (!r_running) begin
                        o_info.status = urtrb_pkg::ST_NOT_RUNNING;
                    end else if (r_rx_head == r_rx_tail) begin
                        o_info.status = urtrb_pkg::ST_RX_EMPTY;
                    end else begin
                        o_rx_re        = 1'b1;
                        o_info.rx_take = 1'b1;
                        n_rx_head      = rx_bump(r_rx_head);
                    end
                end
                urtrb_pkg::OP_TX_PUT: begin
                    if (!r_running) begin
                        o_info.status = urtrb_pkg::ST_NOT_RUNNING;
                    end else begin
                        o_info.tx_offer_valid = r_port_free;
                        if (r_port_free && i_req.port_accepts) begin
                            n_port_free = 1'b0;
                        end else if (tx_tail_inc == r_tx_head) begin
                            o_info.status = urtrb_pkg::ST_TX_OVERFLOW;
                        end else begin
                            o_tx_we   = 1'b1;
                            n_tx_tail = tx_tail_inc;
                        end
                    end
                end
                urtrb_pkg::OP_TX_READY: begin
                    if (!tx_empty) begin
                        o_tx_re               = 1'b1;
                        o_info.tx_offer_valid = 1'b1;
                        o_info.tx_from_ring   = 1'b1;
                        if (i_req.port_accepts) begin
                            n_tx_head = tx_bump(r_tx_head);
                        end else begin
                            n_port_free = 1'b1;
                        end
                    end else begin
                        n_port_free = 1'b1;
                    end
                end
                urtrb_pkg::OP_CLEAR_RX: begin
                    if (!r_running) begin
                        o_info.status = urtrb_pkg::ST_NOT_RUNNING;
                    end else begin
                        n_rx_head = '0;
                        n_rx_tail = '0;
                    end
                end
                urtrb_pkg::OP_CLEAR_TX: begin
                    if (!r_running) begin
                        o_info.status = urtrb_pkg::ST_NOT_RUNNING;
                    end else begin
                        n_tx_head = '0;
                        n_tx_tail = '0;
                    end
                end
                urtrb_pkg::OP_START: begin
                    // refused offer on start leaves the port state unchanged
                    if (!r_running) begin
                        n_running = 1'b1;
                        if (!tx_empty) begin
                            o_tx_re               = 1'b1;
                            o_info.tx_offer_valid = 1'b1;
                            o_info.tx_from_ring   = 1'b1;
                            if (i_req.port_accepts) begin
                                n_tx_head = tx_bump(r_tx_head);
                            end
                        end else begin
                            n_port_free = 1'b1;
                        end
                    end
                end
                urtrb_pkg::OP_STOP: begin
                    n_running   = 1'b0;
                    n_port_free = 1'b0;
                end
                default: begin
                end
            endcase
        end

        o_info.rx_fill = rx_count(n_rx_head, n_rx_tail);
        o_info.tx_fill = tx_count(n_tx_head, n_tx_tail);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_tx_head   <= '0;
            r_tx_tail   <= '0;
            r_port_free <= 1'b0;
            r_running   <= 1'b0;
        end else begin
            r_rx_head   <= n_rx_head;
            r_rx_tail   <= n_rx_tail;
            r_tx_head   <= n_tx_head;
            r_tx_tail   <= n_tx_tail;
            r_port_free <= n_port_free;
            r_running   <= n_running;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/uart_rx_tx_ring_buffers.sv -----
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers
// Receive and transmit byte rings in front of a UART controller.
// ----------------------------------------------------------------------------
// Takes one request per cycle with no bubbles while o_stall is low and
// returns exactly one result per request: the first register stage updates
// the ring pointers and issues the ring read, the second is the output
// register, which lets a new request in while a result waits under stall.
// Each ring keeps one slot empty, so it holds RX_DEPTH-1 / TX_DEPTH-1 bytes;
// the fill counts on the result are the low six bits of the true count.
// Ring contents are not cleared by reset and need no clearing pass.
`default_nettype none

module uart_rx_tx_ring_buffers #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire urtrb_pkg::t_in_req  i_req,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output urtrb_pkg::t_out_res      o_res
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);

    urtrb_pkg::t_ctl_info         ctl_info;
    urtrb_pkg::t_ctl_info         r_a_info;
    urtrb_pkg::t_out_res          r_b_res, n_b_res;
    logic                         r_a_valid, r_b_valid;
    logic                         accept, a_move, b_ready;
    logic                         rx_we, rx_re, tx_we, tx_re;
    logic [RX_AW-1:0]             rx_waddr, rx_raddr;
    logic [TX_AW-1:0]             tx_waddr, tx_raddr;
    logic [urtrb_pkg::BYTE_W-1:0] rx_rdata, tx_rdata;

    assign b_ready = !r_b_valid || !i_stall;
    assign a_move  = r_a_valid && b_ready;
    assign o_stall = r_a_valid && !b_ready;
    assign accept  = i_valid && !o_stall;

    urtrb_ctrl #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req      (i_req),
        .o_info     (ctl_info),
        .o_rx_we    (rx_we),
        .o_rx_re    (rx_re),
        .o_rx_waddr (rx_waddr),
        .o_rx_raddr (rx_raddr),
        .o_tx_we    (tx_we),
        .o_tx_re    (tx_re),
        .o_tx_waddr (tx_waddr),
        .o_tx_raddr (tx_raddr)
    );

    urtrb_mem #(.DEPTH(RX_DEPTH)) u_rx_mem (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (i_req.data_byte),
        .i_re    (rx_re),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rdata)
    );

    urtrb_mem #(.DEPTH(TX_DEPTH)) u_tx_mem (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (i_req.data_byte),
        .i_re    (tx_re),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

    // read data only moves on accept, so it holds while stage A waits
    always_comb begin
        n_b_res.status         = r_a_info.status;
        n_b_res.rx_byte        = r_a_info.rx_take ? rx_rdata : '0;
        n_b_res.tx_offer_valid = r_a_info.tx_offer_valid;
        if (!r_a_info.tx_offer_valid) begin
            n_b_res.tx_offer_byte = '0;
        end else if (r_a_info.tx_from_ring) begin
            n_b_res.tx_offer_byte = tx_rdata;
        end else begin
            n_b_res.tx_offer_byte = r_a_info.tx_in_byte;
        end
        n_b_res.rx_fill = r_a_info.rx_fill;
        n_b_res.tx_fill = r_a_info.tx_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_info <= ctl_info;
        end
        if (a_move) begin
            r_b_res <= n_b_res;
        end
    end

    assign o_valid = r_b_valid;
    assign o_res   = r_b_res;

endmodule

`default_nettype wire

// ----- hw/rtl/urtrb_checker.sv -----
// ----------------------------------------------------------------------------
// urtrb_checker
// Port-level checks for the UART ring buffer block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uart_rx_tx_ring_buffers_macros.svh"

module urtrb_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire urtrb_pkg::t_in_req  i_req,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire urtrb_pkg::t_out_res o_res
);

    `URTRB_ASSERT_RST(a_rst_no_result, !i_rst_n |=> !o_valid, "result after reset")

    `URTRB_ASSERT(a_res_hold, o_valid && i_stall |=> o_valid && $stable(o_res), "stalled result changed")

    `URTRB_ASSERT(a_rx_byte_zero, o_valid && o_res.status != urtrb_pkg::ST_OK |-> o_res.rx_byte == '0, "rx byte on failed request")

    `URTRB_ASSERT(a_offer_zero, o_valid && !o_res.tx_offer_valid |-> o_res.tx_offer_byte == '0, "offer byte without offer")

    `URTRB_ASSERT(a_not_running_quiet, o_valid && o_res.status == urtrb_pkg::ST_NOT_RUNNING |-> !o_res.tx_offer_valid, "offer while not running")

endmodule

bind uart_rx_tx_ring_buffers urtrb_checker u_urtrb_checker (.*);

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UART receive/transmit ring buffer block.
// ----------------------------------------------------------------------------
// A queue of requests (a short directed opening, then randomized traffic
// made of arrival floods, transmit bursts, mixed runs, control changes and
// noise) feeds a clocked driver. A cycle-level model of both rings predicts
// each result on acceptance. A clocked monitor compares every result with
// the oldest prediction. Both sides insert random gaps and calm stretches.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int ITEM_TARGET = 850;
    localparam int IDLE_LIMIT  = 600;
    localparam int DRAIN_WAIT  = 10;
    localparam int MAX_REPORTS = 10;
    localparam int OP_W        = urtrb_pkg::OP_W;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                i_stall = 1'b0;
    urtrb_pkg::t_in_req  i_req   = '0;
    logic                o_stall;
    logic                o_valid;
    urtrb_pkg::t_out_res o_res;

    uart_rx_tx_ring_buffers dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    // Ring model state; 6-bit pointers wrap at the 64-entry depth
    logic [7:0] rx_ring [64];
    logic [7:0] tx_ring [64];
    logic [5:0] rx_head = '0, rx_tail = '0;
    logic [5:0] tx_head = '0, tx_tail = '0;
    logic       port_free = 1'b0;
    logic       running   = 1'b0;

    urtrb_pkg::t_in_req  pending_reqs[$];
    urtrb_pkg::t_out_res expected_results[$];

    int reqs_sent     = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int rx_overwrites = 0;
    int tx_refusals   = 0;
    int bytes_offered = 0;
    int send_wait     = 0;
    int send_calm     = 0;
    int recv_wait     = 0;
    int recv_calm     = 0;
    int idle_cycles   = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Offer the oldest queued byte (start and transmitter-ready)
    function automatic void offer_queued(inout urtrb_pkg::t_out_res res,
                                         input logic accepts,
                                         input logic free_on_refuse);
        if (tx_head != tx_tail) begin
            res.tx_offer_valid = 1'b1;
            res.tx_offer_byte  = tx_ring[tx_head];
            if (accepts)
                tx_head = tx_head + 6'd1;
            else if (free_on_refuse)
                port_free = 1'b1;
        end else begin
            port_free = 1'b1;
        end
    endfunction

    function automatic urtrb_pkg::t_out_res predict_rings(input urtrb_pkg::t_in_req req);
        urtrb_pkg::t_out_res res;
        logic [5:0]          next_tail;
        res = '0;
        case (req.operation)
            urtrb_pkg::OP_RX_ARRIVE: begin
                rx_ring[rx_tail] = req.data_byte;
                rx_tail = rx_tail + 6'd1;
                if (rx_tail == rx_head) begin
                    rx_head = rx_head + 6'd1;
                    res.status = urtrb_pkg::ST_RX_OVERWROTE;
                end
            end
            urtrb_pkg::OP_RX_TAKE: begin
                if (!running) begin
                    res.status = urtrb_pkg::ST_NOT_RUNNING;
                end else if (rx_head == rx_tail) begin
                    res.status = urtrb_pkg::ST_RX_EMPTY;
                end else begin
                    res.rx_byte = rx_ring[rx_head];
                    rx_head = rx_head + 6'd1;
                end
            end
            urtrb_pkg::OP_TX_PUT: begin
                if (!running) begin
                    res.status = urtrb_pkg::ST_NOT_RUNNING;
                end else if (port_free && req.port_accepts) begin
                    res.tx_offer_valid = 1'b1;
                    res.tx_offer_byte  = req.data_byte;
                    port_free = 1'b0;
                end else begin
                    // refused offer falls back to queuing
                    if (port_free) begin
                        res.tx_offer_valid = 1'b1;
                        res.tx_offer_byte  = req.data_byte;
                    end
                    next_tail = tx_tail + 6'd1;
                    if (next_tail == tx_head) begin
                        res.status = urtrb_pkg::ST_TX_OVERFLOW;
                    end else begin
                        tx_ring[tx_tail] = req.data_byte;
                        tx_tail = next_tail;
                    end
                end
            end
            urtrb_pkg::OP_TX_READY: offer_queued(res, req.port_accepts, 1'b1);
            urtrb_pkg::OP_CLEAR_RX: begin
                if (!running) begin
                    res.status = urtrb_pkg::ST_NOT_RUNNING;
                end else begin
                    rx_head = '0;
                    rx_tail = '0;
                end
            end
            urtrb_pkg::OP_CLEAR_TX: begin
                if (!running) begin
                    res.status = urtrb_pkg::ST_NOT_RUNNING;
                end else begin
                    tx_head = '0;
                    tx_tail = '0;
                end
            end
            urtrb_pkg::OP_START: begin
                if (!running) begin
                    running = 1'b1;
                    offer_queued(res, req.port_accepts, 1'b0);
                end
            end
            default: begin
                running   = 1'b0;
                port_free = 1'b0;
            end
        endcase
        res.rx_fill = rx_tail - rx_head;
        res.tx_fill = tx_tail - tx_head;
        if (res.status == urtrb_pkg::ST_RX_OVERWROTE) rx_overwrites++;
        if (res.status == urtrb_pkg::ST_TX_OVERFLOW) tx_refusals++;
        if (res.tx_offer_valid) bytes_offered++;
        return res;
    endfunction

    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left = $urandom_range(15, 50);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    task automatic queue_req(input logic [OP_W-1:0] op, input logic [7:0] data,
                             input logic accepts);
        urtrb_pkg::t_in_req req;
        req.operation    = op;
        req.data_byte    = data;
        req.port_accepts = accepts;
        pending_reqs.push_back(req);
    endtask

    task automatic check_result(input urtrb_pkg::t_out_res got);
        urtrb_pkg::t_out_res want;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected result: %p", got);
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status || got.rx_byte !== want.rx_byte ||
            got.tx_offer_valid !== want.tx_offer_valid ||
            got.tx_offer_byte !== want.tx_offer_byte ||
            got.rx_fill !== want.rx_fill || got.tx_fill !== want.tx_fill) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result %0d mismatch: expected %p, got %p",
                         results_seen, want, got);
        end
    endtask

    // Request driver
    always @(posedge i_clk) begin
        logic took;
        took = i_valid && !o_stall;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (took) begin
                expected_results.push_back(predict_rings(i_req));
                reqs_sent++;
            end
            if (!i_valid || took) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    i_req     <= pending_reqs.pop_front();
                    i_valid   <= 1'b1;
                    send_wait = draw_gap(send_calm);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor, receiver stalls and watchdog
    always @(posedge i_clk) begin
        logic got_res;
        int   hold;
        got_res = o_valid && !i_stall;
        hold    = recv_wait;
        if (i_rst_n) begin
            if (got_res) begin
                check_result(o_res);
                results_seen++;
                hold = draw_gap(recv_calm);
            end
            if (got_res || (i_valid && !o_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        if (hold > 0) begin
            i_stall   <= 1'b1;
            recv_wait = hold - 1;
        end else begin
            i_stall   <= 1'b0;
            recv_wait = 0;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int               n;
        int               directed;
        logic [OP_W-1:0]  op;

        // Directed opening: stopped behavior, start, offers and refusals
        queue_req(urtrb_pkg::OP_RX_TAKE,   8'h00, 1'b0);
        queue_req(urtrb_pkg::OP_TX_PUT,    8'hFF, 1'b1);
        queue_req(urtrb_pkg::OP_CLEAR_RX,  8'h00, 1'b0);
        queue_req(urtrb_pkg::OP_CLEAR_TX,  8'h00, 1'b0);
        queue_req(urtrb_pkg::OP_RX_ARRIVE, 8'h00, 1'b0);
        queue_req(urtrb_pkg::OP_RX_ARRIVE, 8'hFF, 1'b1);
        queue_req(urtrb_pkg::OP_TX_READY,  8'h00, 1'b0);
        queue_req(urtrb_pkg::OP_START,     8'h00, 1'b1);
        queue_req(urtrb_pkg::OP_START,     8'h00, 1'b0);
        queue_req(urtrb_pkg::OP_RX_TAKE,   8'h00, 1'b0);
        queue_req(urtrb_pkg::OP_RX_TAKE,   8'h00, 1'b0);
        queue_req(urtrb_pkg::OP_RX_TAKE,   8'h00, 1'b0);
        queue_req(urtrb_pkg::OP_TX_PUT,    8'hA5, 1'b1);
        queue_req(urtrb_pkg::OP_TX_PUT,    8'h5A, 1'b0);
        queue_req(urtrb_pkg::OP_TX_PUT,    8'hC3, 1'b1);
        queue_req(urtrb_pkg::OP_TX_READY,  8'h00, 1'b0);
        queue_req(urtrb_pkg::OP_TX_PUT,    8'h3C, 1'b0);
        queue_req(urtrb_pkg::OP_TX_READY,  8'h00, 1'b1);
        queue_req(urtrb_pkg::OP_STOP,      8'h00, 1'b0);
        queue_req(urtrb_pkg::OP_START,     8'h00, 1'b0);
        queue_req(urtrb_pkg::OP_STOP,      8'h00, 1'b1);
        queue_req(urtrb_pkg::OP_TX_READY,  8'h00, 1'b1);
        queue_req(urtrb_pkg::OP_START,     8'h00, 1'b1);
        queue_req(urtrb_pkg::OP_RX_ARRIVE, 8'h81, 1'b0);
        queue_req(urtrb_pkg::OP_CLEAR_RX,  8'h00, 1'b1);
        queue_req(urtrb_pkg::OP_TX_PUT,    8'h7E, 1'b0);
        queue_req(urtrb_pkg::OP_CLEAR_TX,  8'h00, 1'b0);
        directed = pending_reqs.size();

        // Randomized traffic, mostly well-formed sequences with random content
        while (pending_reqs.size() < directed + ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    // receive flood, long enough at times to overwrite
                    queue_req(urtrb_pkg::OP_START, 8'($urandom), 1'($urandom));
                    n = $urandom_range(1, 70);
                    repeat (n)
                        queue_req(urtrb_pkg::OP_RX_ARRIVE, 8'($urandom), 1'($urandom));
                    repeat ($urandom_range(0, n + 2))
                        queue_req(urtrb_pkg::OP_RX_TAKE, 8'($urandom), 1'($urandom));
                end
                2, 3: begin
                    // transmit burst with mostly refused offers, then drain
                    queue_req(urtrb_pkg::OP_START, 8'($urandom), 1'($urandom));
                    n = $urandom_range(1, 68);
                    repeat (n)
                        queue_req(urtrb_pkg::OP_TX_PUT, 8'($urandom),
                                  $urandom_range(0, 3) == 0);
                    repeat ($urandom_range(0, n))
                        queue_req(urtrb_pkg::OP_TX_READY, 8'($urandom),
                                  $urandom_range(0, 4) != 0);
                end
                4: begin
                    repeat ($urandom_range(1, 4)) begin
                        case ($urandom_range(0, 3))
                            0: op = urtrb_pkg::OP_START;
                            1: op = urtrb_pkg::OP_STOP;
                            2: op = urtrb_pkg::OP_CLEAR_RX;
                            default: op = urtrb_pkg::OP_CLEAR_TX;
                        endcase
                        queue_req(op, 8'($urandom), 1'($urandom));
                    end
                end
                5, 6, 7: begin
                    queue_req(urtrb_pkg::OP_START, 8'($urandom), 1'($urandom));
                    repeat ($urandom_range(8, 24)) begin
                        case ($urandom_range(0, 8))
                            0, 1: op = urtrb_pkg::OP_RX_ARRIVE;
                            2, 3: op = urtrb_pkg::OP_RX_TAKE;
                            4, 5, 6: op = urtrb_pkg::OP_TX_PUT;
                            default: op = urtrb_pkg::OP_TX_READY;
                        endcase
                        queue_req(op, 8'($urandom), 1'($urandom));
                    end
                end
                default: begin
                    repeat ($urandom_range(1, 10))
                        queue_req(OP_W'($urandom_range(urtrb_pkg::OP_RX_ARRIVE,
                                                       urtrb_pkg::OP_STOP)),
                                  8'($urandom), 1'($urandom));
                end
            endcase
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        mismatches += expected_results.size();
        $display("Ran %0d requests (%0d directed) and checked %0d results, %0d mismatches.",
                 reqs_sent, directed, results_seen, mismatches);
        $display("Saw %0d receive overwrites, %0d transmit refusals, %0d transmit offers.",
                 rx_overwrites, tx_refusals, bytes_offered);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/urtrb_pkg.sv
hw/rtl/urtrb_mem.sv
hw/rtl/urtrb_ctrl.sv
hw/rtl/uart_rx_tx_ring_buffers.sv
hw/rtl/urtrb_checker.sv
dv/tb_top.sv
